### rtl/core/lmfw_pkg.sv
// Package: shared types and codes for the lock manager core.
`timescale 1ns / 1ps
package lmfw_pkg;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_KILL    = 2'd2;

  localparam logic [1:0] RC_DONE  = 2'd0;
  localparam logic [1:0] RC_ERROR = 2'd1;
  localparam logic [1:0] RC_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        process_id;
    logic signed [31:0] lock_id;
  } lmfw_in_t;

  typedef struct packed {
    logic [15:0] dest_process;
    logic [1:0]  reply_code;
    logic        last;
  } lmfw_out_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [31:0] lock;
  } lmfw_held_t;

  typedef struct packed {
    logic [15:0] process;
    logic [31:0] lock;
    logic [15:0] stamp;
  } lmfw_wait_t;

endpackage

### rtl/core/lmfw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module lmfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/lock_manager_fifo_waiters_core.sv
// Top level: lock manager with held-lock table and arrival-ordered wait table.
//
// Usage: one input channel (in_valid/in_ready, in_data of lmfw_in_t) carries
// acquire, release and kill requests. The result channel (out_valid/out_ready,
// out_data of lmfw_out_t) carries replies; last marks the final reply of a
// request. Requests that cause no reply (queued acquire, kill that grants no
// lock, op 3) produce nothing on the result channel.
// One item is worked at a time by a sequencer that walks the held and wait
// memories one entry per cycle in its scans (registered-read RAMs, one read
// port each); the kill walks read, then decide, for each entry. Acquire
// replies after the held scan only (a free wait slot comes from the valid
// flags). Release scans the held table; a successful release then searches
// the wait table for the oldest waiter, and a grant adds the rank-renumbering
// sweep before the final reply. Kill walks every wait entry (a renumbering
// sweep per drop), then every held entry (a waiter search per freed lock and
// a renumbering sweep per grant).
// The valid bits live in flip-flops cleared by reset, so no clearing pass is
// needed; the block accepts an item in the cycle after reset.
// Each reply sits in an output register; while the receiver stalls, the
// sequencer holds when it must stage a reply and no new item is taken.
`timescale 1ns / 1ps
module lock_manager_fifo_waiters_core
  import lmfw_pkg::*;
#(
  parameter int HELD_SLOTS = 16,
  parameter int WAIT_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lmfw_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lmfw_out_t out_data
);
  localparam int HAW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
  localparam int WAW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int HCW = $clog2(HELD_SLOTS + 1);
  localparam int WCW = $clog2(WAIT_SLOTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HSCAN = 4'd1;  // scan held table
  localparam logic [3:0] S_DEC   = 4'd2;  // decide acquire/release
  localparam logic [3:0] S_EMIT  = 4'd3;  // unused; S_GRANT and S_FIN wait for the reply
  localparam logic [3:0] S_GSCAN = 4'd4;  // oldest-waiter search
  localparam logic [3:0] S_GRANT = 4'd5;  // write grant
  localparam logic [3:0] S_REN   = 4'd6;  // renumber ranks above dropped
  localparam logic [3:0] S_KWAIT = 4'd7;  // kill: walk wait table
  localparam logic [3:0] S_KHELD = 4'd8;  // kill: walk held table
  localparam logic [3:0] S_FIN   = 4'd9;  // final marker pass

  logic [3:0] state_r, state_nxt;
  lmfw_in_t req_r, req_nxt;

  logic [HELD_SLOTS-1:0] hv_r, hv_nxt;
  logic [WAIT_SLOTS-1:0] wv_r, wv_nxt;
  logic [15:0] arr_r, arr_nxt;

  // held ram
  logic           h_we;
  logic [HAW-1:0] h_waddr, h_raddr;
  lmfw_held_t     h_wdata, h_rdata;
  // wait ram
  logic           w_we;
  logic [WAW-1:0] w_waddr, w_raddr;
  lmfw_wait_t     w_wdata, w_rdata;

  lmfw_ram #(.WIDTH($bits(lmfw_held_t)), .DEPTH(HELD_SLOTS)) u_held (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );
  lmfw_ram #(.WIDTH($bits(lmfw_wait_t)), .DEPTH(WAIT_SLOTS)) u_wait (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  // scan counters: issue index and data index registered behind it
  logic [HCW-1:0] hcnt_r, hcnt_nxt;
  logic [WCW-1:0] wcnt_r, wcnt_nxt;
  logic           rd_v_r, rd_v_nxt;
  logic [HAW-1:0] hd_r, hd_nxt;
  logic [WAW-1:0] wd_r, wd_nxt;

  logic           hfound_r, hfound_nxt;
  logic [HAW-1:0] hidx_r, hidx_nxt;
  logic [15:0]    howner_r, howner_nxt;
  logic [31:0]    glock_r, glock_nxt;

  logic           best_v_r, best_v_nxt;
  logic [WAW-1:0] best_r, best_nxt;
  lmfw_wait_t     bestd_r, bestd_nxt;
  logic [15:0]    dstamp_r, dstamp_nxt;

  logic [3:0]     ret_r, ret_nxt;      // state after renumber or after a search with no grant

  lmfw_out_t      obuf_r, obuf_nxt;
  logic           obuf_v_r, obuf_v_nxt;
  logic           pend_v_r, pend_v_nxt;
  lmfw_out_t      pend_r, pend_nxt;

  logic [HAW-1:0] hfree;
  logic           hfree_v;
  logic [WAW-1:0] wfree;
  logic           wfree_v;

  always_comb begin
    hfree = '0;
    hfree_v = 1'b0;
    for (int i = HELD_SLOTS - 1; i >= 0; i--) begin
      if (!hv_r[i]) begin
        hfree = HAW'(i);
        hfree_v = 1'b1;
      end
    end
    wfree = '0;
    wfree_v = 1'b0;
    for (int i = WAIT_SLOTS - 1; i >= 0; i--) begin
      if (!wv_r[i]) begin
        wfree = WAW'(i);
        wfree_v = 1'b1;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE) && !obuf_v_r && !pend_v_r;
  assign out_valid = obuf_v_r;
  assign out_data  = obuf_r;

  // Replies are held one behind in pend so that last can be set when the
  // request ends; obuf is the output register.
  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    hv_nxt = hv_r;
    wv_nxt = wv_r;
    arr_nxt = arr_r;
    hcnt_nxt = hcnt_r;
    wcnt_nxt = wcnt_r;
    rd_v_nxt = 1'b0;
    hd_nxt = hd_r;
    wd_nxt = wd_r;
    hfound_nxt = hfound_r;
    hidx_nxt = hidx_r;
    howner_nxt = howner_r;
    glock_nxt = glock_r;
    best_v_nxt = best_v_r;
    best_nxt = best_r;
    bestd_nxt = bestd_r;
    dstamp_nxt = dstamp_r;
    ret_nxt = ret_r;
    obuf_nxt = obuf_r;
    obuf_v_nxt = obuf_v_r;
    pend_v_nxt = pend_v_r;
    pend_nxt = pend_r;
    h_we = 1'b0;
    h_waddr = '0;
    h_wdata = '0;
    h_raddr = hcnt_r[HAW-1:0];
    w_we = 1'b0;
    w_waddr = '0;
    w_wdata = '0;
    w_raddr = wcnt_r[WAW-1:0];

    if (obuf_v_r && out_ready) begin
      obuf_v_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt = in_data;
          hcnt_nxt = '0;
          wcnt_nxt = '0;
          hfound_nxt = 1'b0;
          unique case (in_data.op) inside
            OP_ACQUIRE, OP_RELEASE: state_nxt = S_HSCAN;
            OP_KILL: state_nxt = S_KWAIT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_HSCAN: begin
        if (rd_v_r && hv_r[hd_r] && h_rdata.lock == 32'(req_r.lock_id)
            && !hfound_r) begin
          hfound_nxt = 1'b1;
          hidx_nxt = hd_r;
          howner_nxt = h_rdata.owner;
        end
        if (hcnt_r < HCW'(HELD_SLOTS)) begin
          rd_v_nxt = 1'b1;
          hd_nxt = hcnt_r[HAW-1:0];
          hcnt_nxt = hcnt_r + 1'b1;
        end else if (!rd_v_r) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_FIN;
        if (req_r.op == OP_ACQUIRE) begin
          if (hfound_r && howner_r == req_r.process_id) begin
            pend_v_nxt = 1'b1;
            pend_nxt = '{req_r.process_id, RC_ERROR, 1'b0};
          end else if (hfound_r) begin
            if (!wfree_v) begin
              pend_v_nxt = 1'b1;
              pend_nxt = '{req_r.process_id, RC_FULL, 1'b0};
            end else begin
              w_we = 1'b1;
              w_waddr = wfree;
              w_wdata = '{req_r.process_id, 32'(req_r.lock_id), arr_r};
              wv_nxt[wfree] = 1'b1;
              arr_nxt = arr_r + 16'd1;
            end
          end else if (!hfree_v) begin
            pend_v_nxt = 1'b1;
            pend_nxt = '{req_r.process_id, RC_FULL, 1'b0};
          end else begin
            h_we = 1'b1;
            h_waddr = hfree;
            h_wdata = '{req_r.process_id, 32'(req_r.lock_id)};
            hv_nxt[hfree] = 1'b1;
            pend_v_nxt = 1'b1;
            pend_nxt = '{req_r.process_id, RC_DONE, 1'b0};
          end
        end else begin
          pend_v_nxt = 1'b1;
          if (hfound_r && howner_r == req_r.process_id) begin
            pend_nxt = '{req_r.process_id, RC_DONE, 1'b0};
            hv_nxt[hidx_r] = 1'b0;
            glock_nxt = 32'(req_r.lock_id);
            wcnt_nxt = '0;
            best_v_nxt = 1'b0;
            ret_nxt = S_FIN;
            state_nxt = S_GSCAN;
          end else begin
            pend_nxt = '{req_r.process_id, RC_ERROR, 1'b0};
          end
        end
      end
      S_GSCAN: begin
        if (rd_v_r && wv_r[wd_r] && w_rdata.lock == glock_r &&
            (!best_v_r || w_rdata.stamp < bestd_r.stamp)) begin
          best_v_nxt = 1'b1;
          best_nxt = wd_r;
          bestd_nxt = w_rdata;
        end
        if (wcnt_r < WCW'(WAIT_SLOTS)) begin
          rd_v_nxt = 1'b1;
          wd_nxt = wcnt_r[WAW-1:0];
          wcnt_nxt = wcnt_r + 1'b1;
        end else if (!rd_v_r) begin
          state_nxt = best_v_r ? S_GRANT : ret_r;
        end
      end
      S_GRANT: begin
        // pending reply must be flushed to obuf before a new one is staged
        if (!pend_v_r || !obuf_v_r || out_ready) begin
          if (pend_v_r) begin
            obuf_nxt = pend_r;
            obuf_v_nxt = 1'b1;
          end
          pend_v_nxt = 1'b1;
          pend_nxt = '{bestd_r.process, RC_DONE, 1'b0};
          h_we = 1'b1;
          h_waddr = hidx_r;
          h_wdata = '{bestd_r.process, glock_r};
          hv_nxt[hidx_r] = 1'b1;
          wv_nxt[best_r] = 1'b0;
          dstamp_nxt = bestd_r.stamp;
          if (arr_r != 16'd0) arr_nxt = arr_r - 16'd1;
          wcnt_nxt = '0;
          state_nxt = S_REN;
        end
      end
      S_REN: begin
        if (rd_v_r && wv_r[wd_r] && w_rdata.stamp > dstamp_r) begin
          w_we = 1'b1;
          w_waddr = wd_r;
          w_wdata = w_rdata;
          w_wdata.stamp = w_rdata.stamp - 16'd1;
        end
        // a write-back goes to an entry already read, never to the one being read
        if (wcnt_r < WCW'(WAIT_SLOTS)) begin
          rd_v_nxt = 1'b1;
          wd_nxt = wcnt_r[WAW-1:0];
          wcnt_nxt = wcnt_r + 1'b1;
        end else if (!rd_v_r) begin
          state_nxt = ret_r;
          wcnt_nxt = '0;
          if (ret_r == S_KWAIT) wcnt_nxt = WCW'(best_r) + 1'b1;
          if (ret_r == S_KHELD) hcnt_nxt = HCW'(hidx_r) + 1'b1;
        end
      end
      S_KWAIT: begin
        // one entry per visit: read, then decide
        if (rd_v_r) begin
          if (wv_r[wd_r] && w_rdata.process == req_r.process_id) begin
            wv_nxt[wd_r] = 1'b0;
            dstamp_nxt = w_rdata.stamp;
            best_nxt = wd_r;
            if (arr_r != 16'd0) arr_nxt = arr_r - 16'd1;
            ret_nxt = S_KWAIT;
            wcnt_nxt = '0;
            state_nxt = S_REN;
          end else begin
            wcnt_nxt = WCW'(wd_r) + 1'b1;
          end
        end else if (wcnt_r < WCW'(WAIT_SLOTS)) begin
          rd_v_nxt = 1'b1;
          wd_nxt = wcnt_r[WAW-1:0];
        end else begin
          hcnt_nxt = '0;
          state_nxt = S_KHELD;
        end
      end
      S_KHELD: begin
        if (rd_v_r) begin
          if (hv_r[hd_r] && h_rdata.owner == req_r.process_id) begin
            hv_nxt[hd_r] = 1'b0;
            hidx_nxt = hd_r;
            glock_nxt = h_rdata.lock;
            wcnt_nxt = '0;
            best_v_nxt = 1'b0;
            ret_nxt = S_KHELD;
            state_nxt = S_GSCAN;
          end
          hcnt_nxt = HCW'(hd_r) + 1'b1;
        end else if (hcnt_r < HCW'(HELD_SLOTS)) begin
          rd_v_nxt = 1'b1;
          hd_nxt = hcnt_r[HAW-1:0];
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (!obuf_v_r || out_ready) begin
          obuf_nxt = pend_r;
          obuf_nxt.last = 1'b1;
          obuf_v_nxt = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // S_GSCAN after a no-grant in S_KHELD must resume past the freed slot
    if (state_r == S_GSCAN && state_nxt == S_KHELD) begin
      hcnt_nxt = HCW'(hidx_r) + 1'b1;
    end
    if (state_r == S_REN && state_nxt == S_FIN) begin
      wcnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hv_r <= '0;
      wv_r <= '0;
      arr_r <= '0;
      obuf_v_r <= 1'b0;
      pend_v_r <= 1'b0;
      rd_v_r <= 1'b0;
      hcnt_r <= '0;
      wcnt_r <= '0;
      hfound_r <= 1'b0;
      best_v_r <= 1'b0;
      ret_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      hv_r <= hv_nxt;
      wv_r <= wv_nxt;
      arr_r <= arr_nxt;
      obuf_v_r <= obuf_v_nxt;
      pend_v_r <= pend_v_nxt;
      rd_v_r <= rd_v_nxt;
      hcnt_r <= hcnt_nxt;
      wcnt_r <= wcnt_nxt;
      hfound_r <= hfound_nxt;
      best_v_r <= best_v_nxt;
      ret_r <= ret_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    hd_r <= hd_nxt;
    wd_r <= wd_nxt;
    hidx_r <= hidx_nxt;
    howner_r <= howner_nxt;
    glock_r <= glock_nxt;
    best_r <= best_nxt;
    bestd_r <= bestd_nxt;
    dstamp_r <= dstamp_nxt;
    obuf_r <= obuf_nxt;
    pend_r <= pend_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("reply changed while stalled");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid && state_r == S_IDLE)
    else $error("item taken while busy");
  a_arr_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> arr_r == 16'($countones(wv_r)))
    else $error("arrival count differs from waiter count");
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && pend_v_r && (!obuf_v_r || out_ready) |=> out_data.last)
    else $error("final reply missing last");
endmodule
